// File: src/base64_strict_decoder_macros.svh
// Assertion macros shared by the base64 decoder RTL
`ifndef BASE64_STRICT_DECODER_MACROS_SVH
`define BASE64_STRICT_DECODER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent, outside reset
`define B64SD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64sd: implication check failed");

// Check that a condition holds in the cycle after a reset edge
`define B64SD_ASSERT_AFTER_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("b64sd: post-reset check failed");

`endif

// File: src/b64sd_pkg.sv
// Types, codes and character classification for the base64 decoder
package b64sd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR    = 2'd1;
    localparam logic [1:0] ST_BAD_PADDING = 2'd2;
    localparam logic [1:0] ST_BAD_LENGTH  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [1:0] {
        K_BLANK,
        K_PAD,
        K_DATA,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] sextet;
        logic       last_char;
    } t_token;

    // Map one raw character to its class and sextet value
    function automatic t_token classify(input logic [7:0] c, input logic last);
        t_token tok;
        tok.last_char = last;
        tok.sextet    = 6'd0;
        tok.kind      = K_BAD;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            tok.kind = K_BLANK;
        end else if (c == PAD_CHAR) begin
            tok.kind = K_PAD;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            tok.kind   = K_DATA;
            tok.sextet = 6'(c - 8'd65);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            tok.kind   = K_DATA;
            tok.sextet = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            tok.kind   = K_DATA;
            tok.sextet = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            tok.kind   = K_DATA;
            tok.sextet = 6'd62;
        end else if (c == 8'h2F) begin
            tok.kind   = K_DATA;
            tok.sextet = 6'd63;
        end
        return tok;
    endfunction

endpackage

// File: src/b64sd_front.sv
// Front stage: accept input words and register their classified tokens
module b64sd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64sd_pkg::t_in_word i_word,
    output logic                o_tok_valid,
    input  logic                i_tok_ready,
    output b64sd_pkg::t_token   o_tok
);

    logic              r_valid;
    b64sd_pkg::t_token r_tok;

    // Take a new word when the stage is empty or being drained
    assign o_ready     = !r_valid || i_tok_ready;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Classify on entry
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tok <= b64sd_pkg::classify(i_word.char_code, i_word.last_char);
        end
    end

endmodule

// File: src/b64sd_queue.sv
// Small token queue between the front and back stages
module b64sd_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_not_full,
    input  b64sd_pkg::t_token i_tok,
    input  logic              i_pop,
    output logic              o_not_empty,
    output b64sd_pkg::t_token o_tok
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64sd_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_not_full  = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_tok       = r_mem[r_rd_ptr];
    assign push_ok     = i_push && o_not_full;
    assign pop_ok      = i_pop && o_not_empty;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Store pushed tokens
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

// File: src/b64sd_back.sv
// Back stage: group sextets into bytes, track padding and report status
module b64sd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok_valid,
    output logic                 o_tok_pop,
    input  b64sd_pkg::t_token    i_tok,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64sd_pkg::t_out_word o_word
);

    logic [1:0]           r_group_phase;
    logic [5:0]           r_held;
    logic [1:0]           r_pad_count;
    logic [1:0]           r_length_phase;
    logic                 r_error;
    logic                 r_out_valid;
    b64sd_pkg::t_out_word r_out;

    logic [1:0]           n_group_phase;
    logic [5:0]           n_held;
    logic [1:0]           n_pad_count;
    logic [1:0]           n_length_phase;
    logic                 n_error;
    logic                 have_byte;
    logic [7:0]           byte_val;
    logic [1:0]           status;
    logic                 take;

    // Pop a token whenever the output register can take a result
    assign take      = i_tok_valid && (!r_out_valid || i_ready);
    assign o_tok_pop = take;
    assign o_valid   = r_out_valid;
    assign o_word    = r_out;

    // Step the decode state for the head token
    always_comb begin
        n_group_phase  = r_group_phase;
        n_held         = r_held;
        n_pad_count    = r_pad_count;
        n_length_phase = r_length_phase;
        n_error        = r_error;
        have_byte      = 1'b0;
        byte_val       = 8'd0;
        status         = b64sd_pkg::ST_OK;

        if (i_tok.kind != b64sd_pkg::K_BLANK) begin
            n_length_phase = r_length_phase + 2'd1;
        end

        unique case (i_tok.kind)
            b64sd_pkg::K_BLANK: begin
            end
            b64sd_pkg::K_PAD: begin
                if (r_pad_count != 2'd3) begin
                    n_pad_count = r_pad_count + 2'd1;
                end
            end
            b64sd_pkg::K_BAD: begin
                n_error = 1'b1;
            end
            b64sd_pkg::K_DATA: begin
                if (r_pad_count != 2'd0) begin
                    // drop data that follows padding
                    n_error = 1'b1;
                end else begin
                    n_group_phase = r_group_phase + 2'd1;
                    unique case (r_group_phase)
                        2'd0: begin
                            n_held = i_tok.sextet;
                        end
                        2'd1: begin
                            byte_val  = {r_held, i_tok.sextet[5:4]};
                            n_held    = {2'b00, i_tok.sextet[3:0]};
                            have_byte = 1'b1;
                        end
                        2'd2: begin
                            byte_val  = {r_held[3:0], i_tok.sextet[5:2]};
                            n_held    = {4'b0000, i_tok.sextet[1:0]};
                            have_byte = 1'b1;
                        end
                        2'd3: begin
                            byte_val  = {r_held[1:0], i_tok.sextet};
                            n_held    = 6'd0;
                            have_byte = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Status at message end, first failing check wins
        if (i_tok.last_char) begin
            priority if (n_error) begin
                status = b64sd_pkg::ST_BAD_CHAR;
            end else if (n_pad_count != 2'd0 &&
                         (n_pad_count == 2'd3 || n_length_phase != 2'd0)) begin
                status = b64sd_pkg::ST_BAD_PADDING;
            end else if (n_group_phase == 2'd1) begin
                status = b64sd_pkg::ST_BAD_LENGTH;
            end else begin
                status = b64sd_pkg::ST_OK;
            end
        end
    end

    // Hold decode state, clear it after the last word of a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_phase  <= 2'd0;
            r_held         <= 6'd0;
            r_pad_count    <= 2'd0;
            r_length_phase <= 2'd0;
            r_error        <= 1'b0;
        end else if (take) begin
            if (i_tok.last_char) begin
                r_group_phase  <= 2'd0;
                r_held         <= 6'd0;
                r_pad_count    <= 2'd0;
                r_length_phase <= 2'd0;
                r_error        <= 1'b0;
            end else begin
                r_group_phase  <= n_group_phase;
                r_held         <= n_held;
                r_pad_count    <= n_pad_count;
                r_length_phase <= n_length_phase;
                r_error        <= n_error;
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= have_byte || i_tok.last_char;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.data_byte      <= byte_val;
            r_out.byte_valid     <= have_byte;
            r_out.end_of_message <= i_tok.last_char;
            r_out.status         <= status;
        end
    end

endmodule

// File: src/base64_strict_decoder.sv
// Strict base64 decoder top level: front, token queue and back stage
//
// Input channel i_valid/o_ready carries one character word (char_code and
// last_char). Output channel o_valid/i_ready carries result words: a decoded
// byte (byte_valid set), the end-of-message status (end_of_message set), or
// both. Whitespace yields no word unless it is the last character.
// Throughput is one character per cycle while the receiver keeps i_ready high:
// the back stage updates the decode state once per token. o_valid for a
// result rises once its character has passed the front register, a queue
// slot and the output register, in that order.
// Bytes are sent before the status is known; discard them on a nonzero
// status. Decode state clears after each last character.
// A stalled receiver holds the output register; the queue of QUEUE_DEPTH
// tokens and the front register keep absorbing input until they fill, then
// o_ready drops. Reset (synchronous, active low) empties every stage and
// clears the decode state.
module base64_strict_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  b64sd_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output b64sd_pkg::t_out_word o_word
);

`include "base64_strict_decoder_macros.svh"

    logic              front_valid;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;
    b64sd_pkg::t_token front_tok;
    b64sd_pkg::t_token q_tok;

    b64sd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .o_tok_valid (front_valid),
        .i_tok_ready (q_not_full),
        .o_tok       (front_tok)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .o_not_full  (q_not_full),
        .i_tok       (front_tok),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_tok       (q_tok)
    );

    b64sd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_not_empty),
        .o_tok_pop   (q_pop),
        .i_tok       (q_tok),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );

    // Every result word carries a byte, an end marker, or both
    `B64SD_ASSERT_IMPLIES(a_word_has_content, o_valid, o_word.byte_valid || o_word.end_of_message)
    // Status is only reported on the end word
    `B64SD_ASSERT_IMPLIES(a_status_at_end, o_valid && !o_word.end_of_message, o_word.status == b64sd_pkg::ST_OK)
    // No data value without the byte flag
    `B64SD_ASSERT_IMPLIES(a_byte_zero_when_empty, o_valid && !o_word.byte_valid, o_word.data_byte == 8'd0)
    // Reset empties the output register
    `B64SD_ASSERT_AFTER_RESET(a_reset_clears_out, !o_valid)

endmodule
